// ----- design/spu_pkg.sv -----
// ---------------------------------------------------------------------------
// spu_pkg
// Shared constants and types for the spectrogram phase unwrapper: field
// widths, column store geometry, queue depth and the classified item.
// ---------------------------------------------------------------------------
package spu_pkg;

    // One turn of phase is 2^PHASE_BITS units
    localparam int PHASE_BITS = 16;
    localparam int BIN_W      = 10;
    localparam int VAL_W      = 48;

    // Per-bin column state store
    localparam int MAX_BINS   = 1024;
    localparam int ADDR_W     = $clog2(MAX_BINS);

    // Queue between front and back
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNWRAP_COLS = 1'b0,
        CFG_UNWRAP_BINS = 1'b1
    } t_cfg_idx;

    // Classified item handed from front to back
    typedef struct packed {
        logic signed [PHASE_BITS-1:0] phase;
        logic [BIN_W-1:0]             bin;
        logic                         col_en;
        logic                         col_first;
        logic                         bin_en;
        logic                         bin_first;
    } t_item;

endpackage

// ----- design/spu_front.sv -----
// ---------------------------------------------------------------------------
// spu_front
// Input side: holds the configuration registers, accepts input beats while
// the queue has room and tags each with the passes it needs.
// ---------------------------------------------------------------------------
module spu_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [spu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic                             i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [spu_pkg::PHASE_BITS-1:0] i_phase_in,
    input  logic [spu_pkg::BIN_W-1:0]        i_bin_index,
    input  logic                             i_first_column,
    input  logic                             i_q_full,
    output logic                             o_push,
    output spu_pkg::t_item                   o_item
);
    import spu_pkg::*;

    logic r_cfg_cols;
    logic r_cfg_bins;
    logic bin_in_store;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= 1'b0;
            r_cfg_bins <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_UNWRAP_COLS: r_cfg_cols <= i_cfg_data;
                CFG_UNWRAP_BINS: r_cfg_bins <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept whenever the queue can take the beat
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify: bins outside the store bypass the column pass
    assign bin_in_store = 32'(i_bin_index) < MAX_BINS;

    always_comb begin
        o_item.phase     = i_phase_in;
        o_item.bin       = i_bin_index;
        o_item.col_en    = r_cfg_cols && bin_in_store;
        o_item.col_first = i_first_column;
        o_item.bin_en    = r_cfg_bins;
        o_item.bin_first = (i_bin_index == '0);
    end

endmodule

// ----- design/spu_queue.sv -----
// ---------------------------------------------------------------------------
// spu_queue
// Short register queue that decouples the input side from the unwrap
// pipeline, so either can stall on its own.
// ---------------------------------------------------------------------------
module spu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spu_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output spu_pkg::t_item o_item
);
    import spu_pkg::*;

    localparam logic [Q_AW:0] FULL_CNT = (Q_AW+1)'(Q_DEPTH);

    t_item           r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- design/spu_back.sv -----
// ---------------------------------------------------------------------------
// spu_back
// Unwrap pipeline: reads the per-bin column state, runs the column pass with
// write-back and forwarding, then the bin pass on the running state, and
// holds the result in the output register.
// ---------------------------------------------------------------------------
module spu_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  spu_pkg::t_item                    i_q_item,
    output logic                              o_q_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [spu_pkg::VAL_W-1:0]  o_phase_out,
    output logic                              o_saturated
);
    import spu_pkg::*;

    localparam int WIDE_W = VAL_W + 3;
    localparam logic signed [WIDE_W-1:0] LIM_HI =
        {{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] LIM_LO =
        {{(WIDE_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] TURN_MASK =
        {{(WIDE_W-PHASE_BITS){1'b0}}, {PHASE_BITS{1'b1}}};

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] offset;
        logic                    sat;
    } t_step;

    function automatic logic signed [WIDE_W-1:0] widen(input logic signed [VAL_W-1:0] x);
        return {{(WIDE_W-VAL_W){x[VAL_W-1]}}, x};
    endfunction

    function automatic logic out_of_range(input logic signed [WIDE_W-1:0] x);
        return (x > LIM_HI) || (x < LIM_LO);
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp(input logic signed [WIDE_W-1:0] x);
        if (x > LIM_HI) begin
            return LIM_HI[VAL_W-1:0];
        end else if (x < LIM_LO) begin
            return LIM_LO[VAL_W-1:0];
        end
        return x[VAL_W-1:0];
    endfunction

    // Negative value: keep its position within the turn, i.e. add whole turns
    function automatic logic signed [VAL_W-1:0] make_nonneg(input logic signed [VAL_W-1:0] x);
        if (x[VAL_W-1]) begin
            return {{(VAL_W-PHASE_BITS){1'b0}}, x[PHASE_BITS-1:0]};
        end
        return x;
    endfunction

    // Add the offset if below prev, then the fewest whole turns if still below
    function automatic t_step unwrap_step(input logic signed [VAL_W-1:0] v,
                                          input logic signed [VAL_W-1:0] p,
                                          input logic signed [VAL_W-1:0] o);
        logic signed [WIDE_W-1:0] sum1;
        logic signed [WIDE_W-1:0] gap;
        logic signed [WIDE_W-1:0] turns;
        logic signed [WIDE_W-1:0] sum2;
        logic signed [WIDE_W-1:0] osum;
        logic signed [VAL_W-1:0]  v1;
        logic                     lt1;
        logic                     lt2;
        t_step                    res;
        lt1   = v < p;
        sum1  = widen(v) + widen(o);
        v1    = lt1 ? clamp(sum1) : v;
        lt2   = v1 < p;
        gap   = widen(p) - widen(v1);
        turns = (gap + TURN_MASK) & ~TURN_MASK;
        sum2  = widen(v1) + turns;
        osum  = widen(o) + turns;
        res.value  = lt2 ? clamp(sum2) : v1;
        res.offset = lt2 ? clamp(osum) : o;
        res.sat    = (lt1 && out_of_range(sum1)) ||
                     (lt2 && (out_of_range(sum2) || out_of_range(osum)));
        return res;
    endfunction

    // Column state store: {previous, offset} per bin
    logic [2*VAL_W-1:0]       r_col_mem [MAX_BINS];
    logic [2*VAL_W-1:0]       r_rd_data;

    // Column stage
    logic                     r_s2_valid;
    t_item                    r_s2;
    logic                     r_fwd;
    logic signed [VAL_W-1:0]  r_fwd_prev;
    logic signed [VAL_W-1:0]  r_fwd_off;

    // Bin stage
    logic                     r_s3_valid;
    logic signed [VAL_W-1:0]  r_s3_val;
    logic                     r_s3_sat;
    logic                     r_s3_bin_en;
    logic                     r_s3_bin_first;
    logic signed [VAL_W-1:0]  r_bin_prev;
    logic signed [VAL_W-1:0]  r_bin_off;

    // Output register
    logic                     r_out_valid;
    logic signed [VAL_W-1:0]  r_out_phase;
    logic                     r_out_sat;

    logic                     adv;
    logic                     pop;
    logic                     col_wr;
    logic                     fwd_hit;
    logic signed [VAL_W-1:0]  col_v;
    logic signed [VAL_W-1:0]  mem_prev;
    logic signed [VAL_W-1:0]  mem_off;
    logic signed [VAL_W-1:0]  col_p;
    logic signed [VAL_W-1:0]  col_o;
    t_step                    col_res;
    logic signed [VAL_W-1:0]  col_val;
    logic                     col_sat;
    logic signed [VAL_W-1:0]  bin_p;
    logic signed [VAL_W-1:0]  bin_o;
    t_step                    bin_res;
    logic signed [VAL_W-1:0]  out_val;
    logic                     out_sat;

    // Pipeline moves whenever the output register is free or being taken
    assign adv     = !r_out_valid || i_out_ready;
    assign pop     = adv && i_q_valid;
    assign o_q_pop = pop;

    // Column pass, forwarding the write-back of the previous beat on the same bin
    assign col_v    = {{(VAL_W-PHASE_BITS){r_s2.phase[PHASE_BITS-1]}}, r_s2.phase};
    assign mem_prev = r_fwd ? r_fwd_prev : r_rd_data[2*VAL_W-1:VAL_W];
    assign mem_off  = r_fwd ? r_fwd_off  : r_rd_data[VAL_W-1:0];
    assign col_p    = r_s2.col_first ? make_nonneg(col_v) : mem_prev;
    assign col_o    = r_s2.col_first ? '0 : mem_off;
    assign col_res  = unwrap_step(col_v, col_p, col_o);
    assign col_val  = r_s2.col_en ? col_res.value : col_v;
    assign col_sat  = r_s2.col_en && col_res.sat;
    assign col_wr   = adv && r_s2_valid && r_s2.col_en;
    assign fwd_hit  = col_wr && (i_q_item.bin[ADDR_W-1:0] == r_s2.bin[ADDR_W-1:0]);

    // Bin pass on the running state
    assign bin_p   = r_s3_bin_first ? make_nonneg(r_s3_val) : r_bin_prev;
    assign bin_o   = r_s3_bin_first ? '0 : r_bin_off;
    assign bin_res = unwrap_step(r_s3_val, bin_p, bin_o);
    assign out_val = r_s3_bin_en ? bin_res.value : r_s3_val;
    assign out_sat = r_s3_sat || (r_s3_bin_en && bin_res.sat);

    // Column store read and write-back
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_data <= r_col_mem[i_q_item.bin[ADDR_W-1:0]];
        end
        if (col_wr) begin
            r_col_mem[r_s2.bin[ADDR_W-1:0]] <= {col_res.value, col_res.offset};
        end
    end

    // Stage valids, forwarding flag and running bin state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
            r_bin_prev  <= '0;
            r_bin_off   <= '0;
        end else if (adv) begin
            r_s2_valid  <= pop;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
            if (pop) begin
                r_fwd <= fwd_hit;
            end
            if (r_s3_valid && r_s3_bin_en) begin
                r_bin_prev <= bin_res.value;
                r_bin_off  <= bin_res.offset;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (pop) begin
                r_s2       <= i_q_item;
                r_fwd_prev <= col_res.value;
                r_fwd_off  <= col_res.offset;
            end
            r_s3_val       <= col_val;
            r_s3_sat       <= col_sat;
            r_s3_bin_en    <= r_s2.bin_en;
            r_s3_bin_first <= r_s2.bin_first;
            r_out_phase    <= out_val;
            r_out_sat      <= out_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_phase_out = r_out_phase;
    assign o_saturated = r_out_sat;

endmodule

// ----- design/spectrogram_phase_unwrapper_top.sv -----
// ---------------------------------------------------------------------------
// spectrogram_phase_unwrapper_top
// Spectrogram phase unwrapper: unwraps fixed-point phase along columns per
// bin and along bins within a column, with 48-bit saturated results.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one phase sample per beat
//   with its bin index and first-column flag; the output channel
//   (o_out_valid / i_out_ready) returns one unwrapped phase and a saturation
//   flag per sample, in order.
//   Configuration: write register 0 (column unwrap enable) or 1 (bin unwrap
//   enable) through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
//   Throughput: one sample per cycle unless the receiver stalls. A beat
//   passes through the queue, column stage, bin stage and output register
//   in turn. The per-bin column state sits in a 1024-entry store read one
//   stage ahead of the column update; back-to-back beats on one bin are
//   served by forwarding from the write-back.
//   Reset clears both enables, the running bin state and all pipeline valids;
//   the column store is not cleared, so each bin must be started with a
//   first-column sample before use.
//   When the receiver stalls the result holds, the pipeline holds, and the
//   four-entry queue keeps taking beats until it is full.
// ---------------------------------------------------------------------------
module spectrogram_phase_unwrapper_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [spu_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic                                  i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [spu_pkg::PHASE_BITS-1:0] i_phase_in,
    input  logic [spu_pkg::BIN_W-1:0]             i_bin_index,
    input  logic                                  i_first_column,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [spu_pkg::VAL_W-1:0]      o_phase_out,
    output logic                                  o_saturated
);
    import spu_pkg::*;

    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_item front_item;
    t_item q_item;

    // Accept and classify
    spu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_phase_in     (i_phase_in),
        .i_bin_index    (i_bin_index),
        .i_first_column (i_first_column),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (front_item)
    );

    // Decoupling queue
    spu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Unwrap pipeline
    spu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_phase_out (o_phase_out),
        .o_saturated (o_saturated)
    );

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the spectrogram phase unwrapper. A short table of
// directed beats covers passthrough, field extremes, the negative first
// element and bins seen before any bin zero. Randomised frames follow:
// whole columns, truncated columns and stray beats, under several register
// settings. Results are compared with an in-bench model of the column and
// bin passes or, on typed rows, fixed values. Both channels idle in random bursts.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spu_pkg::*;

    localparam int     PIPE_LATENCY  = 3;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_ITEMS   = 125;
    localparam int     PEND_DEPTH    = 64;
    localparam int     ROW_DEPTH     = 32;
    localparam longint TURN          = longint'(1) << PHASE_BITS;
    localparam longint VAL_MAX       = (longint'(1) << (VAL_W - 1)) - 1;
    localparam longint VAL_MIN       = -(longint'(1) << (VAL_W - 1));

    typedef struct packed {
        bit signed [PHASE_BITS-1:0] phase;
        bit [BIN_W-1:0]             bin;
        bit                         first;
    } t_sample;

    typedef struct packed {
        bit signed [VAL_W-1:0] phase;
        bit                    sat;
    } t_unwrapped;

    typedef struct {
        bit      col_en;
        bit      bin_en;
        t_sample smp;
        bit      typed;
        longint  want;
    } t_row;

    // Pass enables per random phase: bit 1 column pass, bit 0 bin pass
    bit [1:0] phase_modes [RANDOM_PHASES] = '{2'b11, 2'b00, 2'b10, 2'b01, 2'b11,
                                              2'b10, 2'b11, 2'b01, 2'b11, 2'b11};

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_idx   = CFG_UNWRAP_COLS;
    logic                       cfg_data  = 1'b0;
    logic                       smp_valid = 1'b0;
    logic signed [PHASE_BITS-1:0] smp_phase = '0;
    logic [BIN_W-1:0]           smp_bin   = '0;
    logic                       smp_first = 1'b0;
    logic                       res_ready = 1'b0;
    logic                       in_ready;
    logic                       out_valid;
    logic signed [VAL_W-1:0]    phase_out;
    logic                       saturated;

    // Model state: column store, running bin state and pass enables
    longint     col_prev    [MAX_BINS];
    longint     col_off     [MAX_BINS];
    bit         col_written [MAX_BINS];
    longint     run_prev = 0;
    longint     run_off  = 0;
    bit         cfg_cols = 1'b0;
    bit         cfg_bins = 1'b0;

    // Expected results in a ring, directed rows in a flat table
    t_unwrapped pending_unwraps [PEND_DEPTH];
    int         pend_wr        = 0;
    int         pend_rd        = 0;
    t_row       directed_rows  [ROW_DEPTH];
    int         row_count      = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         beats_sent     = 0;
    int         stall_left     = 0;
    bit         gaps_on        = 1'b0;
    bit         stalls_on      = 1'b0;
    bit         quiet          = 1'b0;

    spectrogram_phase_unwrapper_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (smp_valid),
        .o_in_ready     (in_ready),
        .i_phase_in     (smp_phase),
        .i_bin_index    (smp_bin),
        .i_first_column (smp_first),
        .o_out_valid    (out_valid),
        .i_out_ready    (res_ready),
        .o_phase_out    (phase_out),
        .o_saturated    (saturated)
    );

    always #10 clk = ~clk;

    // ---- unwrap model ------------------------------------------------------

    function automatic longint clamp_val(longint v, inout bit sat);
        if (v > VAL_MAX) begin
            sat = 1'b1;
            return VAL_MAX;
        end
        if (v < VAL_MIN) begin
            sat = 1'b1;
            return VAL_MIN;
        end
        return v;
    endfunction

    // Fewest whole turns that lift a value by at least gap (gap > 0)
    function automatic longint turns_needed(longint gap);
        return (gap + TURN - 1) >>> PHASE_BITS;
    endfunction

    function automatic longint lift_nonneg(longint v, inout bit sat);
        if (v < 0)
            v = clamp_val(v + turns_needed(-v) * TURN, sat);
        return v;
    endfunction

    // Shared rule: below prev add the offset, then whole turns until v reaches prev
    function automatic longint turn_rule(longint v, inout longint prev, inout longint off,
                                         inout bit sat);
        longint lift;
        if (v < prev)
            v = clamp_val(v + off, sat);
        if (v < prev) begin
            lift = turns_needed(prev - v) * TURN;
            v    = clamp_val(v + lift, sat);
            off  = clamp_val(off + lift, sat);
        end
        prev = v;
        return v;
    endfunction

    function automatic t_unwrapped unwrap_sample(t_sample s);
        longint     v;
        bit         sat;
        t_unwrapped r;
        v   = longint'(s.phase);
        sat = 1'b0;
        // Column pass: restart the bin on a first-column beat
        if (cfg_cols && int'(s.bin) < MAX_BINS) begin
            if (s.first) begin
                col_prev[s.bin]    = lift_nonneg(v, sat);
                col_off[s.bin]     = 0;
                col_written[s.bin] = 1'b1;
            end
            v = turn_rule(v, col_prev[s.bin], col_off[s.bin], sat);
        end
        // Bin pass: bin zero restarts the running state
        if (cfg_bins) begin
            if (s.bin == '0) begin
                run_prev = lift_nonneg(v, sat);
                run_off  = 0;
            end
            v = turn_rule(v, run_prev, run_off, sat);
        end
        r.phase = v[VAL_W-1:0];
        r.sat   = sat;
        return r;
    endfunction

    // ---- stimulus helpers --------------------------------------------------

    function automatic void add_row(bit col_en, bit bin_en, int phase, int bin, bit first,
                                    bit typed, longint want);
        t_row row;
        row.col_en    = col_en;
        row.bin_en    = bin_en;
        row.smp.phase = phase[PHASE_BITS-1:0];
        row.smp.bin   = bin[BIN_W-1:0];
        row.smp.first = first;
        row.typed     = typed;
        row.want      = want;
        directed_rows[row_count] = row;
        row_count++;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_count < 100)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Hold the sender off until every pending result has come back
    task automatic drain_pending();
        smp_valid <= 1'b0;
        while (pend_wr != pend_rd)
            @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit value);
        drain_pending();
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_UNWRAP_COLS)
            cfg_cols = value;
        else
            cfg_bins = value;
    endtask

    task automatic apply_mode(bit col_en, bit bin_en);
        if (col_en != cfg_cols)
            write_reg(CFG_UNWRAP_COLS, col_en);
        if (bin_en != cfg_bins)
            write_reg(CFG_UNWRAP_BINS, bin_en);
    endtask

    // Drive one beat, wait for acceptance and queue its expected result
    task automatic send_sample(t_sample s, bit typed, longint want);
        t_unwrapped r;
        // Never read a column entry that has not been started
        if (cfg_cols && !col_written[s.bin])
            s.first = 1'b1;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            smp_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        smp_valid <= 1'b1;
        smp_phase <= s.phase;
        smp_bin   <= s.bin;
        smp_first <= s.first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = unwrap_sample(s);
        if (typed) begin
            r.phase = want[VAL_W-1:0];
            r.sat   = 1'b0;
        end
        pending_unwraps[pend_wr % PEND_DEPTH] = r;
        pend_wr++;
        beats_sent++;
    endtask

    // One frame of columns with a smooth, wrapping phase; broken frames cut
    // columns short and scatter the first-column flag
    task automatic send_frame(bit broken);
        int        nbins;
        int        ncols;
        int        len;
        int        bin_inc;
        int        col_inc;
        bit [31:0] base;
        bit [31:0] acc;
        t_sample   s;
        nbins   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(2, 8);
        ncols   = $urandom_range(1, 6);
        base    = $urandom;
        bin_inc = int'($urandom_range(0, 40000)) - 20000;
        col_inc = int'($urandom_range(0, 40000)) - 20000;
        for (int c = 0; c < ncols; c++) begin
            len = broken ? $urandom_range(1, nbins) : nbins;
            for (int b = 0; b < len; b++) begin
                acc     = base + b * bin_inc + c * col_inc + $urandom_range(0, 1023);
                s.phase = acc[PHASE_BITS-1:0];
                s.bin   = b[BIN_W-1:0];
                if (broken)
                    s.first = (c == 0) ? ($urandom_range(0, 1) == 1)
                                       : ($urandom_range(0, 5) == 0);
                else
                    s.first = (c == 0);
                send_sample(s, 1'b0, 0);
            end
        end
    endtask

    // ---- result checking ---------------------------------------------------

    always @(posedge clk) begin : check_results
        t_unwrapped want;
        if (rst_n && out_valid && res_ready) begin
            if (pend_wr == pend_rd) begin
                report_mismatch("result with none pending", longint'(phase_out), 0);
            end else begin
                want = pending_unwraps[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (phase_out !== want.phase)
                    report_mismatch("phase_out", longint'(phase_out), longint'(want.phase));
                if (saturated !== want.sat)
                    report_mismatch("saturated", longint'(saturated), longint'(want.sat));
            end
        end
    end

    // Receiver stalls in bursts while stalls are on and the bench is not quiet
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stalls_on && !quiet && $urandom_range(0, 5) == 0) begin
            res_ready  <= 1'b0;
            stall_left <= $urandom_range(1, 9) - 1;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---- stimulus ----------------------------------------------------------

    initial begin : stimulus
        t_sample   s;
        bit [31:0] r32;
        int        start;
        int        pick;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        //        cols bins phase   bin   first typed want
        // Passthrough after reset, field extremes
        add_row(0, 0, -32768,    0, 1, 1, -32768);
        add_row(0, 0,  32767, 1023, 0, 1,  32767);
        add_row(0, 0,      0,  512, 0, 1,      0);
        // Bin pass alone, first beats before any bin zero
        add_row(0, 1,   -100,    7, 0, 0,      0);
        add_row(0, 1, -32768,    0, 0, 1,  32768);
        add_row(0, 1,  32767,    1, 0, 0,      0);
        add_row(0, 1, -32768,    2, 0, 0,      0);
        add_row(0, 1,      0,    3, 0, 0,      0);
        // Column pass alone, including the negative first element
        add_row(1, 0,  32767,    0, 1, 1,  32767);
        add_row(1, 0, -32768, 1023, 1, 1,  32768);
        add_row(1, 0, -32768,    0, 0, 0,      0);
        add_row(1, 0,  32767, 1023, 0, 0,      0);
        add_row(1, 0,    100,    0, 0, 0,      0);
        // Both passes
        add_row(1, 1,     -1,    0, 1, 0,      0);
        add_row(1, 1,  20000,    1, 1, 0,      0);
        add_row(1, 1, -20000,    2, 1, 0,      0);
        add_row(1, 1,  30000,    0, 0, 0,      0);
        add_row(1, 1, -30000,    1, 0, 0,      0);
        add_row(1, 1,      5,    2, 0, 0,      0);
        // Column pass off, then back on: its state must carry over
        add_row(0, 1,      1,    0, 0, 0,      0);
        add_row(0, 1,     -1,    1, 0, 0,      0);
        add_row(1, 1, -32768,    0, 0, 0,      0);
        add_row(1, 1,  32767,    1, 0, 0,      0);
        add_row(0, 0,  12345,    5, 1, 1,  12345);

        for (int i = 0; i < row_count; i++) begin
            apply_mode(directed_rows[i].col_en, directed_rows[i].bin_en);
            send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, each under its own pass setting; the last one runs flat out
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_mode(phase_modes[p][1], phase_modes[p][0]);
            gaps_on    = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            stalls_on <= ($urandom_range(0, 3) != 0);
            quiet     <= (p == RANDOM_PHASES - 1);
            start      = beats_sent;
            while (beats_sent - start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    send_frame(1'b0);
                end else if (pick == 7) begin
                    send_frame(1'b1);
                end else begin
                    // Stray beats anywhere in the bin range
                    repeat ($urandom_range(1, 4)) begin
                        r32     = $urandom;
                        s.phase = r32[PHASE_BITS-1:0];
                        s.bin   = r32[PHASE_BITS+BIN_W-1:PHASE_BITS];
                        s.first = r32[31];
                        send_sample(s, 1'b0, 0);
                    end
                end
                if ($urandom_range(0, 19) == 0)
                    drain_pending();
            end
        end

        drain_pending();
        repeat (PIPE_LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0 && pend_wr == pend_rd)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
